// ===== hw/rtl/md5h_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 hasher package
// Round constants, shift amounts, message word schedule and chaining init.
// ----------------------------------------------------------------------------
package md5h_pkg;

	localparam int unsigned NumWords = 4;

	localparam logic [31:0] CHAIN_INIT [NumWords] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] SINE_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_TAB [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_byte;
	} md5h_msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} md5h_dig_t;

	function automatic logic [3:0] md5h_msg_idx(input logic [5:0] r);
		logic [7:0] rx;
		logic [7:0] t;
		rx = {2'b00, r};
		unique case (r[5:4])
			2'd0: t = rx;
			2'd1: t = (rx << 2) + rx + 8'd1;
			2'd2: t = (rx << 1) + rx + 8'd5;
			2'd3: t = (rx << 3) - rx;
			default: t = rx;
		endcase
		return t[3:0];
	endfunction

	function automatic logic [4:0] md5h_rot(input logic [5:0] r);
		return ROT_TAB[{r[5:4], r[1:0]}];
	endfunction

	function automatic logic [31:0] md5h_rol(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] d;
		d = {x, x} << s;
		return d[63:32];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/md5h_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 hasher channels
// Message byte channel and digest word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface md5h_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last_byte;

	modport source (output valid, data_byte, has_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

interface md5h_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/md5_byte_stream_hasher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 byte stream hasher
// Packs message bytes into a 16x32 block memory, runs one MD5 round per
// cycle and streams out the four digest words at the end of each message.
//
// msg: one word per byte; has_byte marks a message byte, last_byte closes
//   the message (a word with has_byte low and last_byte high ends it with no
//   extra byte). A byte that is not last and does not fill the block keeps msg.ready high.
// digest: four words A, B, C, D, last_word set on D, each held in an output
//   register until taken.
// A filled block holds msg.ready low through 64 rounds fed from the
//   block memory through a two-stage read and constant-add path, plus the
//   chaining add. Closing a message costs one or two padded blocks and
//   then four digest words, one per cycle while the receiver takes them; a
//   stalled receiver holds the block in that phase.
// Reset loads the MD5 initial chaining words and clears the byte count;
//   the block memory is not cleared, padding masks unwritten bytes.
// ----------------------------------------------------------------------------
module md5_byte_stream_hasher_unit (
	input  wire          clk,
	input  wire          arst_n,
	md5h_msg_if.sink     msg,
	md5h_dig_if.source   digest
);
	import md5h_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_COMP = 4'b0010,
		ST_ADD  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t      state_q;
	logic [6:0]  cnt_q;
	logic [6:0]  lim_q;
	logic        mark_q;
	logic        len_q;
	logic        fin_q;
	logic        pad2_q;
	logic        done_q;
	logic [63:0] count_q;
	logic [31:0] chain_q [NumWords];
	logic [31:0] wa_q, wb_q, wc_q, wd_q;
	logic [1:0]  idx_q;
	logic        ov_q;
	md5h_dig_t   out_q;

	logic [31:0] blk_mem_q [16];
	logic [31:0] rdata_s1;
	logic [3:0]  sel_s1;
	logic [31:0] kw_s2;

	logic        msg_acc;
	logic [5:0]  pos_cur;
	logic [5:0]  pos_fin;
	logic [5:0]  r1, r2;
	logic [3:0]  rd_sel;
	logic [63:0] bit_len;
	logic [31:0] w_sub;
	logic [31:0] f_val;
	logic [31:0] rnd_sum;
	logic [31:0] nb;
	logic [31:0] add_a, add_b, add_c, add_d;
	logic        out_ld;

	assign msg.ready      = (state_q == ST_IDLE);
	assign msg_acc        = msg.valid && msg.ready;
	assign pos_cur        = count_q[5:0];
	assign pos_fin        = pos_cur + {5'd0, msg.has_byte};
	assign r1             = cnt_q[5:0] - 6'd1;
	assign r2             = cnt_q[5:0] - 6'd2;
	assign rd_sel         = md5h_msg_idx(cnt_q[5:0]);
	assign bit_len        = {count_q[60:0], 3'b000};

	assign digest.valid       = ov_q;
	assign digest.digest_word = out_q.digest_word;
	assign digest.word_index  = out_q.word_index;
	assign digest.last_word   = out_q.last_word;
	assign out_ld             = (state_q == ST_EMIT) && (!ov_q || digest.ready);

	// substitute padding and length bytes over the block memory word
	always_comb begin
		logic [6:0] j;
		w_sub = '0;
		for (int k = 0; k < 4; k++) begin
			j = {1'b0, sel_s1, 2'(k)};
			if (j < lim_q) begin
				w_sub[8*k +: 8] = rdata_s1[8*k +: 8];
			end else if (mark_q && (j == lim_q)) begin
				w_sub[8*k +: 8] = PAD_MARK;
			end else if (len_q && (sel_s1[3:1] == 3'b111)) begin
				w_sub[8*k +: 8] = bit_len[{sel_s1[0], 2'(k), 3'b000} +: 8];
			end else begin
				w_sub[8*k +: 8] = 8'h00;
			end
		end
	end

	always_comb begin
		unique case (r2[5:4])
			2'd0: f_val = (wb_q & wc_q) | (~wb_q & wd_q);
			2'd1: f_val = (wd_q & wb_q) | (~wd_q & wc_q);
			2'd2: f_val = wb_q ^ wc_q ^ wd_q;
			2'd3: f_val = wc_q ^ (wb_q | ~wd_q);
			default: f_val = '0;
		endcase
		rnd_sum = wa_q + f_val + kw_s2;
		nb      = wb_q + md5h_rol(rnd_sum, md5h_rot(r2));
	end

	assign add_a = chain_q[0] + wa_q;
	assign add_b = chain_q[1] + wb_q;
	assign add_c = chain_q[2] + wc_q;
	assign add_d = chain_q[3] + wd_q;

	// block memory and round feed path
	always_ff @(posedge clk) begin
		if (msg_acc && msg.has_byte) begin
			blk_mem_q[count_q[5:2]][{count_q[1:0], 3'b000} +: 8] <= msg.data_byte;
		end
		rdata_s1 <= blk_mem_q[rd_sel];
		sel_s1   <= rd_sel;
		kw_s2    <= SINE_TAB[r1] + w_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			lim_q   <= '0;
			mark_q  <= 1'b0;
			len_q   <= 1'b0;
			fin_q   <= 1'b0;
			pad2_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
			for (int i = 0; i < NumWords; i++) chain_q[i] <= CHAIN_INIT[i];
			wa_q    <= '0;
			wb_q    <= '0;
			wc_q    <= '0;
			wd_q    <= '0;
			idx_q   <= '0;
			ov_q    <= 1'b0;
			out_q   <= '0;
		end else begin
			if (out_ld) begin
				ov_q              <= 1'b1;
				out_q.digest_word <= chain_q[idx_q];
				out_q.word_index  <= idx_q;
				out_q.last_word   <= (idx_q == 2'd3);
			end else if (digest.ready) begin
				ov_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						if (msg.has_byte) count_q <= count_q + 64'd1;
						wa_q <= chain_q[0];
						wb_q <= chain_q[1];
						wc_q <= chain_q[2];
						wd_q <= chain_q[3];
						cnt_q <= '0;
						if (msg.has_byte && (pos_cur == 6'd63)) begin
							lim_q   <= 7'd64;
							mark_q  <= 1'b0;
							len_q   <= 1'b0;
							fin_q   <= msg.last_byte;
							state_q <= ST_COMP;
						end else if (msg.last_byte) begin
							lim_q   <= {1'b0, pos_fin};
							mark_q  <= 1'b1;
							len_q   <= (pos_fin < 6'd56);
							pad2_q  <= (pos_fin >= 6'd56);
							done_q  <= (pos_fin < 6'd56);
							state_q <= ST_COMP;
						end
					end
				end
				ST_COMP: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q >= 7'd2) begin
						wa_q <= wd_q;
						wd_q <= wc_q;
						wc_q <= wb_q;
						wb_q <= nb;
					end
					if (cnt_q == 7'd65) state_q <= ST_ADD;
				end
				ST_ADD: begin
					chain_q[0] <= add_a;
					chain_q[1] <= add_b;
					chain_q[2] <= add_c;
					chain_q[3] <= add_d;
					wa_q  <= add_a;
					wb_q  <= add_b;
					wc_q  <= add_c;
					wd_q  <= add_d;
					cnt_q <= '0;
					priority if (fin_q) begin
						fin_q   <= 1'b0;
						lim_q   <= {1'b0, pos_cur};
						mark_q  <= 1'b1;
						len_q   <= (pos_cur < 6'd56);
						pad2_q  <= (pos_cur >= 6'd56);
						done_q  <= (pos_cur < 6'd56);
						state_q <= ST_COMP;
					end else if (pad2_q) begin
						pad2_q  <= 1'b0;
						lim_q   <= '0;
						mark_q  <= 1'b0;
						len_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_COMP;
					end else if (done_q) begin
						done_q  <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_ld) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							for (int i = 0; i < NumWords; i++) chain_q[i] <= CHAIN_INIT[i];
							count_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== tb/md5_byte_stream_hasher_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 byte stream hasher testbench
// Feeds byte messages through the msg channel: a short directed table with
// known digests, then random messages around the block and padding edges,
// with idle noise words. A local MD5 computes each digest, and every word on
// the digest channel is checked against it. Both channels stall at random,
// and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module md5_byte_stream_hasher_unit_test;
	import md5h_pkg::*;

	localparam int ITEM_TARGET = 410;
	localparam int QUIET_ITEMS = 60;
	localparam int WORD_TARGET = 40;
	localparam int LONG_HOLD = 400;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	typedef struct packed {
		logic [7:0]   data_byte;
		logic         has_byte;
		logic         last_byte;
		logic         typed;
		logic [127:0] digest;
	} stim_row_t;

	logic clk;
	logic arst_n;

	md5h_msg_if msg();
	md5h_dig_if digest();

	md5_byte_stream_hasher_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.digest (digest)
	);

	logic [31:0] chain_regs [4];
	logic [7:0]  blk_bytes [64];
	logic [63:0] byte_total;
	logic [31:0] sine_k [64];
	int          round_shift [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
		4, 11, 16, 23, 6, 10, 15, 21};

	md5h_dig_t digest_due [$];
	int failures = 0;
	int items_sent = 0;
	int words_predicted = 0;
	int words_taken = 0;
	bit quiet = 0;
	bit long_hold_done = 0;

	// empty message, "a", "abc" (with an idle word inside), then ff 00 closed by marker
	stim_row_t directed_rows [10] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1,
			{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec}},
		'{8'h5a, 1'b0, 1'b0, 1'b0, 128'h0},
		'{8'h61, 1'b1, 1'b1, 1'b1,
			{32'hb975c10c, 32'ha8b6f1c0, 32'he299c331, 32'h61267769}},
		'{8'h61, 1'b1, 1'b0, 1'b0, 128'h0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 128'h0},
		'{8'hff, 1'b0, 1'b0, 1'b0, 128'h0},
		'{8'h63, 1'b1, 1'b1, 1'b1,
			{32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128}},
		'{8'hff, 1'b1, 1'b0, 1'b0, 128'h0},
		'{8'h00, 1'b1, 1'b0, 1'b0, 128'h0},
		'{8'hc3, 1'b0, 1'b1, 1'b0, 128'h0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void note_failure(input string what);
		if (failures < MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, what);
		failures++;
	endfunction

	task automatic restart_chain();
		chain_regs[0] = IV_A;
		chain_regs[1] = IV_B;
		chain_regs[2] = IV_C;
		chain_regs[3] = IV_D;
		byte_total = '0;
	endtask

	task automatic md5_compress();
		logic [31:0] m [16];
		logic [31:0] a, b, c, d, f, t;
		int g;
		for (int i = 0; i < 16; i++)
			m[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
		a = chain_regs[0];
		b = chain_regs[1];
		c = chain_regs[2];
		d = chain_regs[3];
		for (int r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			t = d;
			d = c;
			c = b;
			b = b + rotl32(a + f + sine_k[r] + m[g], round_shift[(r / 16) * 4 + r % 4]);
			a = t;
		end
		chain_regs[0] += a;
		chain_regs[1] += b;
		chain_regs[2] += c;
		chain_regs[3] += d;
	endtask

	task automatic hash_byte_word(input md5h_msg_t w, output bit done, output logic [127:0] dg);
		int pos;
		logic [63:0] bits;
		done = 1'b0;
		dg = '0;
		if (w.has_byte) begin
			pos = int'(byte_total[5:0]);
			blk_bytes[pos] = w.data_byte;
			byte_total++;
			if (pos == 63)
				md5_compress();
		end
		if (w.last_byte) begin
			pos = int'(byte_total[5:0]);
			blk_bytes[pos] = PAD_BYTE;
			pos++;
			if (pos > 56) begin
				for (int i = pos; i < 64; i++)
					blk_bytes[i] = 8'h00;
				md5_compress();
				pos = 0;
			end
			for (int i = pos; i < 56; i++)
				blk_bytes[i] = 8'h00;
			bits = byte_total << 3;
			for (int i = 0; i < 8; i++)
				blk_bytes[56 + i] = bits[8*i +: 8];
			md5_compress();
			dg = {chain_regs[0], chain_regs[1], chain_regs[2], chain_regs[3]};
			done = 1'b1;
			restart_chain();
		end
	endtask

	task automatic send_word(input md5h_msg_t w, input bit typed, input logic [127:0] typed_dg);
		int gap;
		bit done;
		logic [127:0] dg;
		md5h_dig_t r;
		gap = 0;
		if (!quiet && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 16);
		while (gap > 0) begin
			msg.valid = 1'b0;
			@(negedge clk);
			gap--;
		end
		msg.data_byte = w.data_byte;
		msg.has_byte = w.has_byte;
		msg.last_byte = w.last_byte;
		msg.valid = 1'b1;
		do @(posedge clk); while (!msg.ready);
		hash_byte_word(w, done, dg);
		if (done) begin
			if (typed)
				dg = typed_dg;
			for (int i = 0; i < 4; i++) begin
				r.digest_word = dg[127 - 32*i -: 32];
				r.word_index = 2'(i);
				r.last_word = (i == 3);
				digest_due.push_back(r);
				words_predicted++;
			end
		end
		if (w.has_byte || w.last_byte)
			items_sent++;
		if (items_sent >= ITEM_TARGET - QUIET_ITEMS)
			quiet = 1'b1;
		@(negedge clk);
	endtask

	// receiver: random stall bursts, one long hold-off while a digest is waiting
	initial begin
		int hold;
		hold = 0;
		digest.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				digest.ready = 1'b0;
			end else if (!long_hold_done && words_taken >= 20 && digest.valid) begin
				long_hold_done = 1'b1;
				hold = LONG_HOLD - 1;
				digest.ready = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 16) - 1;
				digest.ready = 1'b0;
			end else begin
				digest.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : take_digest
		md5h_dig_t want;
		if (arst_n && digest.valid && digest.ready) begin
			words_taken++;
			if (digest_due.size() == 0) begin
				note_failure($sformatf("unexpected word %h index %0d last %b",
					digest.digest_word, digest.word_index, digest.last_word));
			end else begin
				want = digest_due.pop_front();
				if (digest.digest_word !== want.digest_word
						|| digest.word_index !== want.word_index
						|| digest.last_word !== want.last_word)
					note_failure($sformatf("expected %h/%0d/%b, got %h/%0d/%b",
						want.digest_word, want.word_index, want.last_word,
						digest.digest_word, digest.word_index, digest.last_word));
			end
		end
	end

	initial begin
		real v;
		int len;
		bit end_with_byte;
		md5h_msg_t w;
		arst_n = 1'b0;
		msg.valid = 1'b0;
		msg.data_byte = 8'h00;
		msg.has_byte = 1'b0;
		msg.last_byte = 1'b0;
		for (int i = 0; i < 64; i++) begin
			v = $sin(real'(i + 1));
			if (v < 0.0)
				v = -v;
			sine_k[i] = 32'(longint'($floor(v * 4294967296.0)));
		end
		restart_chain();
		for (int i = 0; i < 64; i++)
			blk_bytes[i] = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			w.data_byte = directed_rows[i].data_byte;
			w.has_byte = directed_rows[i].has_byte;
			w.last_byte = directed_rows[i].last_byte;
			send_word(w, directed_rows[i].typed, directed_rows[i].digest);
		end

		while (items_sent < ITEM_TARGET || words_predicted < WORD_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: len = $urandom_range(0, 12);
				5, 6: begin
					case ($urandom_range(0, 7))
						0: len = 55;
						1: len = 56;
						2: len = 57;
						3: len = 63;
						4: len = 64;
						5: len = 65;
						6: len = 119;
						default: len = 128;
					endcase
				end
				7, 8: len = $urandom_range(13, 70);
				default: len = $urandom_range(100, 140);
			endcase
			end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					w.data_byte = 8'($urandom_range(0, 255));
					w.has_byte = 1'b0;
					w.last_byte = 1'b0;
					send_word(w, 1'b0, '0);
				end
				w.data_byte = 8'($urandom_range(0, 255));
				w.has_byte = 1'b1;
				w.last_byte = end_with_byte && (k == len - 1);
				send_word(w, 1'b0, '0);
			end
			if (!end_with_byte) begin
				w.data_byte = 8'($urandom_range(0, 255));
				w.has_byte = 1'b0;
				w.last_byte = 1'b1;
				send_word(w, 1'b0, '0);
			end
		end
		msg.valid = 1'b0;

		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
